// ===== rtl/crf_pkg.sv =====
// Shared constants, types and records of the checksummed frame receiver.
`default_nettype none
package crf_pkg;

  localparam logic [7:0] SyncByte   = 8'hAA;
  localparam logic [7:0] CmdVolume  = 8'h17;
  localparam logic [7:0] VolumeTag  = 8'h04;
  localparam logic [7:0] CmdStatus  = 8'h1E;
  localparam logic [7:0] CmdNull    = 8'h00;
  localparam logic [3:0] VolumeMask = 4'hF;
  localparam logic [7:0] AckOpcode  = 8'h14;

  localparam logic [7:0] VolumeLen  = 8'd4;
  localparam logic [7:0] StatusLen  = 8'd8;
  localparam logic [7:0] NullLen    = 8'd3;

  localparam int unsigned HeadDepth = 7;
  localparam int unsigned HeadIdxW  = $clog2(HeadDepth);

  localparam int unsigned MidDepthDefault = 2;
  localparam int unsigned OutDepthDefault = 2;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PhHunt  = 4'b0001,
    PhLenHi = 4'b0010,
    PhLenLo = 4'b0100,
    PhBody  = 4'b1000
  } phase_e;

  // Status flags as stored.
  typedef struct packed {
    logic streaming;
    logic pairing;
    logic link;
    logic power;
  } flags_t;

  // Finished frame, classified by the front end.
  typedef struct packed {
    logic       checksum_ok;
    logic [7:0] command_code;
    logic [7:0] payload_length;
    logic       ack_needed;
    logic       vol_wr;
    logic [3:0] vol;
    logic       flags_wr;
    flags_t     flags;
  } frame_rec_t;

  // One result beat.
  typedef struct packed {
    logic       checksum_ok;
    logic [7:0] command_code;
    logic [7:0] payload_length;
    logic       ack_needed;
    logic [3:0] speaker_volume;
    flags_t     flags;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/crf_fifo.sv =====
// Small first-in first-out queue with the head shown combinationally.
`default_nettype none
module crf_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/crf_front.sv =====
// Front end: frame parser, checksum accumulator and command classifier.
`default_nettype none
module crf_front
  import crf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       byte_valid_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            rec_push_o,
  output frame_rec_t      rec_o
);

  phase_e     phase_q, phase_d;
  logic       zps_q, zps_d;
  logic [7:0] len_q, len_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] head_q [HeadDepth];
  logic [7:0] sum_next;
  logic       head_wr;
  logic       is_vol, is_status, is_null, ok;

  assign sum_next = sum_q + rx_byte_i;

  // Classify from the kept head bytes; only consulted on the checksum beat.
  assign ok        = (sum_next == 8'h00);
  assign is_vol    = (head_q[0] == CmdVolume) && (len_q == VolumeLen) &&
                     (head_q[2] == VolumeTag);
  assign is_status = (head_q[0] == CmdStatus) && (len_q == StatusLen);
  assign is_null   = (head_q[0] == CmdNull) && (len_q == NullLen);

  always_comb begin
    rec_o.checksum_ok    = ok;
    rec_o.command_code   = head_q[0];
    rec_o.payload_length = len_q;
    rec_o.ack_needed     = ok && (is_vol || is_status || is_null);
    rec_o.vol_wr         = ok && is_vol;
    rec_o.vol            = head_q[3][3:0] & VolumeMask;
    rec_o.flags_wr       = ok && !is_vol && is_status;
    rec_o.flags.power     = (head_q[1] != 8'h00);
    rec_o.flags.link      = (head_q[2] != 8'h00);
    rec_o.flags.pairing   = (head_q[1] == 8'h01);
    rec_o.flags.streaming = (head_q[6] != 8'h00);
  end

  always_comb begin
    phase_d    = phase_q;
    zps_d      = zps_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    sum_d      = sum_q;
    head_wr    = 1'b0;
    rec_push_o = 1'b0;
    if (byte_valid_i) begin
      unique case (phase_q)
        PhHunt: begin
          if (rx_byte_i == 8'h00 && !zps_q) begin
            zps_d = 1'b1;
          end else if (rx_byte_i == SyncByte) begin
            zps_d   = 1'b0;
            sum_d   = 8'h00;
            phase_d = PhLenHi;
          end else begin
            zps_d = 1'b0;
          end
        end
        PhLenHi: begin
          sum_d   = sum_next;
          phase_d = PhLenLo;
        end
        PhLenLo: begin
          len_d = rx_byte_i;
          cnt_d = 8'h00;
          if (rx_byte_i == 8'h00) begin
            sum_d   = 8'h00;
            zps_d   = 1'b0;
            phase_d = PhHunt;
          end else begin
            sum_d   = sum_next;
            phase_d = PhBody;
          end
        end
        PhBody: begin
          if (cnt_q < len_q) begin
            sum_d   = sum_next;
            head_wr = (cnt_q < 8'(HeadDepth));
            cnt_d   = cnt_q + 8'd1;
          end else begin
            rec_push_o = 1'b1;
            sum_d      = 8'h00;
            cnt_d      = 8'h00;
            zps_d      = 1'b0;
            phase_d    = PhHunt;
          end
        end
        default: begin
          sum_d   = 8'h00;
          cnt_d   = 8'h00;
          zps_d   = 1'b0;
          phase_d = PhHunt;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      zps_q   <= 1'b0;
      len_q   <= 8'h00;
      cnt_q   <= 8'h00;
      sum_q   <= 8'h00;
    end else begin
      phase_q <= phase_d;
      zps_q   <= zps_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_wr) begin
      head_q[cnt_q[HeadIdxW-1:0]] <= rx_byte_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/crf_back.sv =====
// Back end: applies classified frames to the stored volume and status.
`default_nettype none
module crf_back
  import crf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       rec_valid_i,
  input  wire frame_rec_t rec_i,
  output logic            rec_pop_o,
  input  wire logic       res_full_i,
  output logic            res_push_o,
  output result_t         res_o
);

  logic [3:0] vol_q, vol_d;
  flags_t     flags_q, flags_d;

  assign rec_pop_o  = rec_valid_i && !res_full_i;
  assign res_push_o = rec_pop_o;

  always_comb begin
    vol_d   = rec_i.vol_wr ? rec_i.vol : vol_q;
    flags_d = rec_i.flags_wr ? rec_i.flags : flags_q;
    res_o.checksum_ok    = rec_i.checksum_ok;
    res_o.command_code   = rec_i.command_code;
    res_o.payload_length = rec_i.payload_length;
    res_o.ack_needed     = rec_i.ack_needed;
    res_o.speaker_volume = vol_d;
    res_o.flags          = flags_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q   <= 4'h0;
      flags_q <= '0;
    end else if (rec_pop_o) begin
      vol_q   <= vol_d;
      flags_q <= flags_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/checksummed_frame_receiver_core.sv =====
// Top level of the checksummed frame receiver: parser, frame queue, decoder, result queue.
//
//   Channel   Handshake            Payload
//   -------   ------------------   -----------------------------------------------
//   input     push / full          rx_byte_i
//   result    pop / empty          checksum_ok_o, command_code_o, payload_length_o,
//                                  ack_needed_o, speaker_volume_o, power_on_o,
//                                  link_connected_o, pairing_mode_o,
//                                  streaming_active_o
//
// One received byte is taken every cycle while full is low; the parser never holds a beat back.
// A result enters the frame queue at the edge that accepts its checksum byte; the decoder
// then moves it into the result queue, stalling while that queue is full.
// full rises only while the frame queue between parser and decoder is full; empty is low
// whenever the result queue holds a beat.
// Reset is asynchronous and active low; it returns the parser to the sync hunt and
// clears the stored volume and status. The kept payload bytes have no reset.
`default_nettype none
module checksummed_frame_receiver_core
  import crf_pkg::*;
#(
  parameter int unsigned MidDepth = MidDepthDefault,
  parameter int unsigned OutDepth = OutDepthDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] rx_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic            checksum_ok_o,
  output logic [7:0]      command_code_o,
  output logic [7:0]      payload_length_o,
  output logic            ack_needed_o,
  output logic [3:0]      speaker_volume_o,
  output logic            power_on_o,
  output logic            link_connected_o,
  output logic            pairing_mode_o,
  output logic            streaming_active_o
);

  logic       byte_fire;
  logic       rec_push, rec_pop, rec_empty, rec_full;
  frame_rec_t rec_in, rec_out;
  logic       res_push, res_full;
  result_t    res_in, res_out;

  // Accept a byte whenever the frame queue can take a finished frame.
  assign full      = rec_full;
  assign byte_fire = push && !rec_full;

  crf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_fire),
    .rx_byte_i    (rx_byte_i),
    .rec_push_o   (rec_push),
    .rec_o        (rec_in)
  );

  // Decouple parsing from decoding so either side can stall on its own.
  crf_fifo #(
    .Width ($bits(frame_rec_t)),
    .Depth (MidDepth)
  ) u_rec_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .data_i  (rec_in),
    .full_o  (rec_full),
    .pop_i   (rec_pop),
    .data_o  (rec_out),
    .empty_o (rec_empty)
  );

  crf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (!rec_empty),
    .rec_i       (rec_out),
    .rec_pop_o   (rec_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Hold finished results until the consumer pops them.
  crf_fifo #(
    .Width ($bits(result_t)),
    .Depth (OutDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign checksum_ok_o      = res_out.checksum_ok;
  assign command_code_o     = res_out.command_code;
  assign payload_length_o   = res_out.payload_length;
  assign ack_needed_o       = res_out.ack_needed;
  assign speaker_volume_o   = res_out.speaker_volume;
  assign power_on_o         = res_out.flags.power;
  assign link_connected_o   = res_out.flags.link;
  assign pairing_mode_o     = res_out.flags.pairing;
  assign streaming_active_o = res_out.flags.streaming;

endmodule
`default_nettype wire

// ===== rtl/crf_checker.sv =====
// Port-level checks of the frame receiver, bound to its top level.
`default_nettype none
module crf_checker
  import crf_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       push,
  input wire logic       full,
  input wire logic [7:0] rx_byte_i,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic       checksum_ok_o,
  input wire logic [7:0] command_code_o,
  input wire logic [7:0] payload_length_o,
  input wire logic       ack_needed_o,
  input wire logic [3:0] speaker_volume_o,
  input wire logic       power_on_o,
  input wire logic       link_connected_o,
  input wire logic       pairing_mode_o,
  input wire logic       streaming_active_o
);

  // Both queues come out of reset drained.
  a_reset_drained: assert property (@(posedge clk_i)
    !rst_ni |-> (empty && !full))
    else $error("queues not drained in reset");

  // An ack is only requested for a good frame.
  a_ack_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && ack_needed_o) |-> checksum_ok_o)
    else $error("ack without good checksum");

  // An ack is only requested for a recognized command.
  a_ack_known_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && ack_needed_o) |->
      ((command_code_o == CmdVolume && payload_length_o == VolumeLen) ||
       (command_code_o == CmdStatus && payload_length_o == StatusLen) ||
       (command_code_o == CmdNull   && payload_length_o == NullLen)))
    else $error("ack for unrecognized command");

  // A waiting result beat holds until popped.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(checksum_ok_o) &&
      $stable(command_code_o) && $stable(payload_length_o) &&
      $stable(ack_needed_o) && $stable(speaker_volume_o)))
    else $error("result beat changed while waiting");

endmodule

bind checksummed_frame_receiver_core crf_checker u_crf_checker (.*);
`default_nettype wire

// ===== verif/frame_scoreboard_pkg.sv =====
// Frame parser prediction and result scoreboard for the checksummed frame receiver bench.
package frame_scoreboard_pkg;
  import crf_pkg::*;

  class frame_scoreboard;
    phase_e     phase;
    bit         prefix_seen;
    logic [7:0] frame_len;
    logic [7:0] body_count;
    logic [7:0] sum;
    logic [7:0] head [HeadDepth];
    logic [3:0] volume;
    flags_t     flags;

    result_t    pending_frames [$];
    int         bytes_seen;
    int         frames_checked;
    int         good_frames;
    int         acked_frames;
    int         mismatches;

    function new();
      phase       = PhHunt;
      prefix_seen = 1'b0;
      frame_len   = '0;
      body_count  = '0;
      sum         = '0;
      volume      = '0;
      flags       = '0;
      foreach (head[i]) head[i] = '0;
    endfunction

    function void restart_hunt();
      phase       = PhHunt;
      prefix_seen = 1'b0;
      sum         = '0;
      body_count  = '0;
    endfunction

    // Decode a frame whose sum came out zero; return 1 when an ack is due.
    function bit apply_command();
      flags_t f;
      if (head[0] == CmdVolume && frame_len == VolumeLen && head[2] == VolumeTag) begin
        volume = head[3][3:0] & VolumeMask;
        return 1'b1;
      end
      if (head[0] == CmdStatus && frame_len == StatusLen) begin
        f           = '0;
        f.power     = (head[1] != 8'h00);
        f.link      = (head[2] != 8'h00);
        f.pairing   = (head[1] == 8'h01);
        f.streaming = (head[6] != 8'h00);
        flags       = f;
        return 1'b1;
      end
      return (head[0] == CmdNull && frame_len == NullLen);
    endfunction

    // Advance the parser by one accepted byte; queue a result on a checksum byte.
    function void parse_byte(logic [7:0] v);
      result_t r;
      bit      ok;
      bit      ack;
      bytes_seen++;
      case (phase)
        PhLenHi: begin
          sum   = sum + v;
          phase = PhLenLo;
        end
        PhLenLo: begin
          sum       = sum + v;
          frame_len = v;
          if (v == 8'h00) begin
            restart_hunt();
          end else begin
            body_count = '0;
            phase      = PhBody;
          end
        end
        PhBody: begin
          sum = sum + v;
          if (body_count < frame_len) begin
            if (body_count < 8'(HeadDepth)) head[body_count[2:0]] = v;
            body_count = body_count + 8'd1;
          end else begin
            ok               = (sum == 8'h00);
            ack              = ok ? apply_command() : 1'b0;
            r.checksum_ok    = ok;
            r.command_code   = head[0];
            r.payload_length = frame_len;
            r.ack_needed     = ack;
            r.speaker_volume = volume;
            r.flags          = flags;
            pending_frames.push_back(r);
            restart_hunt();
          end
        end
        default: begin
          if (v == 8'h00 && !prefix_seen) begin
            prefix_seen = 1'b1;
          end else if (v == SyncByte) begin
            sum   = '0;
            phase = PhLenHi;
          end else begin
            prefix_seen = 1'b0;
            phase       = PhHunt;
          end
        end
      endcase
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] seen);
      if (want !== seen) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, seen);
        mismatches++;
      end
    endfunction

    function void check_frame(result_t got);
      result_t want;
      if (pending_frames.size() == 0) begin
        $error("result beat popped with no frame pending");
        mismatches++;
        return;
      end
      want = pending_frames.pop_front();
      frames_checked++;
      if (want.checksum_ok) good_frames++;
      if (want.ack_needed) acked_frames++;
      compare_field("checksum_ok", 8'(want.checksum_ok), 8'(got.checksum_ok));
      compare_field("command_code", want.command_code, got.command_code);
      compare_field("payload_length", want.payload_length, got.payload_length);
      compare_field("ack_needed", 8'(want.ack_needed), 8'(got.ack_needed));
      compare_field("speaker_volume", 8'(want.speaker_volume), 8'(got.speaker_volume));
      compare_field("power_on", 8'(want.flags.power), 8'(got.flags.power));
      compare_field("link_connected", 8'(want.flags.link), 8'(got.flags.link));
      compare_field("pairing_mode", 8'(want.flags.pairing), 8'(got.flags.pairing));
      compare_field("streaming_active", 8'(want.flags.streaming), 8'(got.flags.streaming));
    endfunction

    function int pending();
      return pending_frames.size();
    endfunction
  endclass

endpackage

// ===== verif/testbench.sv =====
// Top-level bench: streams received bytes into the frame receiver and scores every result beat.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import crf_pkg::*;
  import frame_scoreboard_pkg::*;

  localparam int ClkHalf           = 5;
  localparam int ResetCycles       = 6;
  localparam int RandomBytesPerMix = 600;
  localparam int CycleLimit        = 200000;
  localparam int SettleCycles      = 8;

  logic       clk_i     = 1'b0;
  logic       rst_ni;
  logic       push      = 1'b0;
  logic [7:0] rx_byte_i = 8'h00;
  logic       pop       = 1'b0;
  logic       full;
  logic       empty;
  logic       checksum_ok_o;
  logic [7:0] command_code_o;
  logic [7:0] payload_length_o;
  logic       ack_needed_o;
  logic [3:0] speaker_volume_o;
  logic       power_on_o;
  logic       link_connected_o;
  logic       pairing_mode_o;
  logic       streaming_active_o;

  // Idle odds in percent; the main sequence changes them per stimulus mix.
  int unsigned send_idle_pct    = 0;
  int unsigned result_stall_pct = 0;
  int          cycle_count      = 0;

  frame_scoreboard tracker = new();
  result_t         popped_frame;

  checksummed_frame_receiver_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .rx_byte_i         (rx_byte_i),
    .empty             (empty),
    .pop               (pop),
    .checksum_ok_o     (checksum_ok_o),
    .command_code_o    (command_code_o),
    .payload_length_o  (payload_length_o),
    .ack_needed_o      (ack_needed_o),
    .speaker_volume_o  (speaker_volume_o),
    .power_on_o        (power_on_o),
    .link_connected_o  (link_connected_o),
    .pairing_mode_o    (pairing_mode_o),
    .streaming_active_o(streaming_active_o)
  );

  always #ClkHalf clk_i = ~clk_i;

  // Pack the result ports in the package record order so one check covers them all.
  assign popped_frame = {checksum_ok_o, command_code_o, payload_length_o, ack_needed_o,
                         speaker_volume_o, streaming_active_o, pairing_mode_o,
                         link_connected_o, power_on_o};

  // Receiver side: decide pop afresh every cycle from the current stall odds.
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= result_stall_pct);
  end

  // Watch both handshakes at the edge. Score the outgoing beat before feeding the
  // incoming byte; a result never leaves in the cycle its checksum byte arrives.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) tracker.check_frame(popped_frame);
      if (push && !full) tracker.parse_byte(rx_byte_i);
    end
  end

  // Watchdog: end the run if the flow ever stops moving.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $error("timed out after %0d cycles with %0d results pending",
             cycle_count, tracker.pending());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Bytes lean toward 0x00 and 0x01 so that flag and prefix decisions flip often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one byte after idle cycles drawn one at a time at the sender's idle odds,
  // and hold it until it is accepted.
  // Leave push high on return so back-to-back beats need no extra edge.
  task automatic send_byte(input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    rx_byte_i <= value;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // Send a framed body. A nonzero skew corrupts the checksum byte.
  task automatic send_frame(input bit prefix, input logic [7:0] len_hi,
                            input logic [7:0] len_lo, input logic [7:0] body[$],
                            input logic [7:0] skew);
    logic [7:0] sum;
    sum = len_hi + len_lo;
    foreach (body[i]) sum = sum + body[i];
    if (prefix) send_byte(8'h00);
    send_byte(SyncByte);
    send_byte(len_hi);
    send_byte(len_lo);
    foreach (body[i]) send_byte(body[i]);
    send_byte(8'h00 - sum + skew);
  endtask

  // Drop push and hold off until every predicted result has been popped.
  task automatic wait_for_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned kind;
    int          mix_goal;
    logic [7:0]  lo;
    logic [7:0]  skew;
    logic [7:0]  body [$];

    rst_ni <= 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Hunt handling first: a stray byte, a prefix zero, then a
    // second zero, which counts as a bad sync byte.
    send_byte(8'h55);
    send_byte(8'h00);
    send_byte(8'h00);
    // Zero low length: back to the hunt with no result.
    send_byte(SyncByte);
    send_byte(8'h7F);
    send_byte(8'h00);
    // Volume command behind a prefix, all-ones high length and volume nibble.
    body = {CmdVolume, 8'h00, VolumeTag, 8'hFF};
    send_frame(1'b1, 8'hFF, VolumeLen, body, 8'h00);
    // Status command with every flag set; the eighth byte is summed but not kept.
    body = {CmdStatus, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h80, 8'hFF};
    send_frame(1'b0, 8'h00, StatusLen, body, 8'h00);
    // Null command: ack only.
    body = {CmdNull, 8'h7F, 8'h01};
    send_frame(1'b1, 8'h80, NullLen, body, 8'h00);
    // Bad checksum on a volume frame: result still comes, stored volume holds.
    body = {CmdVolume, 8'h00, VolumeTag, 8'h03};
    send_frame(1'b0, 8'h00, VolumeLen, body, 8'h01);
    // Shortest body.
    body = {8'hFF};
    send_frame(1'b0, 8'h00, 8'h01, body, 8'h00);
    wait_for_results();

    // Random part in three idle mixes: sender-light/receiver-heavy, the reverse,
    // then full rate. Drain after each mix so the sender sits out a whole pause.
    for (int mix = 0; mix < 3; mix++) begin
      case (mix)
        0: begin
          send_idle_pct    = 19;
          result_stall_pct = 58;
        end
        1: begin
          send_idle_pct    = 58;
          result_stall_pct = 19;
        end
        default: begin
          send_idle_pct    = 0;
          result_stall_pct = 0;
        end
      endcase
      mix_goal = tracker.bytes_seen + RandomBytesPerMix;
      while (tracker.bytes_seen < mix_goal) begin
        kind = $urandom_range(99);
        body.delete();
        if (kind < 6) begin
          // Line noise while hunting.
          repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
        end else if (kind < 10) begin
          // Header with zero low length.
          if ($urandom_range(1) != 0) send_byte(8'h00);
          send_byte(SyncByte);
          send_byte(pick_byte());
          send_byte(8'h00);
        end else begin
          lo = 8'($urandom_range(12, 1));
          if (kind < 28)      lo = VolumeLen;
          else if (kind < 44) lo = StatusLen;
          else if (kind < 52) lo = NullLen;
          else if (kind < 54) lo = 8'($urandom_range(255, 200));
          repeat (lo) body.push_back(pick_byte());
          if (kind < 28) begin
            body[0] = CmdVolume;
            if ($urandom_range(3) != 0) body[2] = VolumeTag;
          end else if (kind < 44) begin
            body[0] = CmdStatus;
          end else if (kind < 52) begin
            body[0] = CmdNull;
          end else if (kind < 64) begin
            // Known command code with an arbitrary length: mostly a near miss.
            case ($urandom_range(2))
              0:       body[0] = CmdVolume;
              1:       body[0] = CmdStatus;
              default: body[0] = CmdNull;
            endcase
          end
          // Now and then break the framing: one byte short or one byte over.
          case ($urandom_range(49))
            0:       if (body.size() > 1) void'(body.pop_back());
            1:       body.push_back(pick_byte());
            default: ;
          endcase
          skew = ($urandom_range(99) < 20) ? 8'($urandom_range(255, 1)) : 8'h00;
          send_frame($urandom_range(1) != 0, pick_byte(), lo, body, skew);
        end
      end
      wait_for_results();
    end

    // Settle: let any stray beat show up before the verdict.
    result_stall_pct = 0;
    repeat (SettleCycles) @(posedge clk_i);

    $display("Run covered %0d received bytes and %0d frame results (%0d good checksum, %0d acked).",
             tracker.bytes_seen, tracker.frames_checked, tracker.good_frames,
             tracker.acked_frames);
    $display("Idle mixes: sender 19%%/receiver 58%%, the reverse, then full rate; %0d mismatches.",
             tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
